>>> rtl/core/silu_activation_fp16_macros.svh
// assertion macros shared by the silu activation checker
`ifndef SILU_ACTIVATION_FP16_MACROS_SVH
`define SILU_ACTIVATION_FP16_MACROS_SVH

// property checked on every rising edge outside reset
`define SILU_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("silu activation check failed");

// property checked on every rising edge, reset included
`define SILU_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("silu activation check failed");

`endif

>>> rtl/core/silu_pkg.sv
// shared types, constants and rounding function for the silu activation block
package silu_pkg;

  typedef struct packed {
    logic        valid;
    logic        last;
    logic [15:0] x_bits;
  } tag_t;

  localparam logic [15:0] SIGN_MASK = 16'h8000;
  localparam logic [15:0] HALF_QNAN = 16'h7E00;
  localparam logic [15:0] HALF_PINF = 16'h7C00;
  localparam logic [14:0] INF_MAG   = 15'h7C00;

  // exp(n) saturates to +inf for n >= 12 and to +0 for n <= -18
  localparam logic [14:0] EXP_OVF_MAG = 15'h4A00;
  localparam logic [14:0] EXP_UNF_MAG = 15'h4C80;

  // fixed-point constants for range reduction
  localparam logic signed [17:0] LOG2E_Q16 = 18'sd94548;
  localparam logic signed [40:0] LN2_Q40   = 41'sh0B17217F7D2;

  // taylor coefficients 1/i! with 32 fraction bits
  localparam int HORNER_DEG = 9;
  localparam logic signed [33:0] COEF [0:HORNER_DEG] = '{
    34'(64'd4294967296),
    34'(64'd4294967296),
    34'(64'd4294967296 / 64'd2),
    34'(64'd4294967296 / 64'd6),
    34'(64'd4294967296 / 64'd24),
    34'(64'd4294967296 / 64'd120),
    34'(64'd4294967296 / 64'd720),
    34'(64'd4294967296 / 64'd5040),
    34'(64'd4294967296 / 64'd40320),
    34'(64'd4294967296 / 64'd362880)
  };

  localparam int DIV_STEPS = 13;

  // round a value 1.sig * 2^e to binary16, nearest even, subnormals included
  function automatic logic [15:0] round_pack(input logic sgn, input logic signed [7:0] e,
                                             input logic [35:0] sig, input logic sticky);
    logic signed [7:0] dd;
    logic [3:0]        d;
    logic [59:0]       ext;
    logic [10:0]       keep;
    logic              guard;
    logic              rest;
    logic              inc;
    logic [14:0]       base;
    logic [14:0]       mag;
    dd = -8'sd14 - e;
    if (e >= -8'sd14) begin
      d = 4'd0;
    end else if (dd > 8'sd13) begin
      d = 4'd13;
    end else begin
      d = dd[3:0];
    end
    ext   = {sig, 24'd0} >> d;
    keep  = ext[59:49];
    guard = ext[48];
    rest  = (|ext[47:0]) | sticky;
    inc   = guard & (rest | keep[0]);
    base  = (e >= -8'sd14) ? 15'(e + 8'sd14) : 15'd0;
    mag   = (base << 10) + 15'(keep) + 15'(inc);
    if (e > 8'sd15) begin
      round_pack = {sgn, INF_MAG};
    end else begin
      round_pack = {sgn, mag};
    end
  endfunction

endpackage

>>> rtl/core/silu_exp.sv
// pipelined exp(-x) unit: range reduction, horner taylor series, rounding to half
module silu_exp (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  silu_pkg::tag_t  in_tag,
  output silu_pkg::tag_t  out_tag,
  output logic [15:0]     e_bits
);

  localparam int NS = silu_pkg::HORNER_DEG;

  // decode of n = -x
  logic [15:0]        n_bits;
  logic [4:0]         n_ef;
  logic [9:0]         n_man;
  logic [10:0]        n_sig;
  logic [29:0]        n_mag;
  logic               special_next;
  logic [15:0]        spbits_next;
  logic signed [30:0] nfix_next;

  always_comb begin
    n_bits = in_tag.x_bits ^ silu_pkg::SIGN_MASK;
    n_ef   = n_bits[14:10];
    n_man  = n_bits[9:0];
    n_sig  = {n_ef != 5'd0, n_man};
    n_mag  = 30'(n_sig) << ((n_ef == 5'd0) ? 5'd0 : n_ef - 5'd1);
    nfix_next = n_bits[15] ? -$signed({1'b0, n_mag}) : $signed({1'b0, n_mag});
    special_next = 1'b1;
    spbits_next  = 16'd0;
    if (n_ef == 5'h1F && n_man != 10'd0) begin
      spbits_next = silu_pkg::HALF_QNAN;
    end else if (!n_bits[15] && n_bits[14:0] >= silu_pkg::EXP_OVF_MAG) begin
      spbits_next = silu_pkg::HALF_PINF;
    end else if (n_bits[15] && n_bits[14:0] >= silu_pkg::EXP_UNF_MAG) begin
      spbits_next = 16'd0;
    end else begin
      special_next = 1'b0;
    end
  end

  silu_pkg::tag_t     tag0;
  logic               special0;
  logic [15:0]        spbits0;
  logic signed [30:0] nfix0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag0 <= '0;
    end else if (adv) begin
      tag0 <= in_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      special0 <= special_next;
      spbits0  <= spbits_next;
      nfix0    <= nfix_next;
    end
  end

  // k = round(n * log2 e)
  logic signed [48:0] prod1;
  logic signed [48:0] prod1_rnd;
  logic signed [5:0]  k_next;

  assign prod1     = nfix0 * silu_pkg::LOG2E_Q16;
  assign prod1_rnd = prod1 + (49'sd1 <<< 39);
  assign k_next    = 6'(prod1_rnd >>> 40);

  silu_pkg::tag_t     tag1;
  logic               special1;
  logic [15:0]        spbits1;
  logic signed [30:0] nfix1;
  logic signed [5:0]  k1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
    end else if (adv) begin
      tag1 <= tag0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      special1 <= special0;
      spbits1  <= spbits0;
      nfix1    <= nfix0;
      k1       <= k_next;
    end
  end

  // r = n - k * ln2, 32 fraction bits
  logic signed [47:0] r40;
  logic signed [33:0] r_next;

  assign r40    = (48'(nfix1) <<< 16) - (k1 * silu_pkg::LN2_Q40);
  assign r_next = 34'(r40 >>> 8);

  silu_pkg::tag_t     tag_h     [0:NS];
  logic               special_h [0:NS];
  logic [15:0]        spbits_h  [0:NS];
  logic signed [5:0]  k_h       [0:NS];
  logic signed [33:0] r_h       [0:NS];
  logic signed [33:0] p_h       [0:NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_h[0] <= '0;
    end else if (adv) begin
      tag_h[0] <= tag1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      special_h[0] <= special1;
      spbits_h[0]  <= spbits1;
      k_h[0]       <= k1;
      r_h[0]       <= r_next;
      p_h[0]       <= silu_pkg::COEF[NS];
    end
  end

  // one horner step per stage
  for (genvar j = 1; j <= NS; j++) begin : g_horner
    logic signed [67:0] prod;
    assign prod = r_h[j-1] * p_h[j-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_h[j] <= '0;
      end else if (adv) begin
        tag_h[j] <= tag_h[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        special_h[j] <= special_h[j-1];
        spbits_h[j]  <= spbits_h[j-1];
        k_h[j]       <= k_h[j-1];
        r_h[j]       <= r_h[j-1];
        p_h[j]       <= silu_pkg::COEF[NS-j] + $signed(prod[65:32]);
      end
    end
  end

  // scale by 2^k, normalize and round
  logic [35:0]       fsig;
  logic signed [7:0] fexp;
  logic [15:0]       e_next;

  always_comb begin
    if (p_h[NS][32]) begin
      fsig = {p_h[NS][32:0], 3'd0};
      fexp = 8'(k_h[NS]);
    end else begin
      fsig = {p_h[NS][31:0], 4'd0};
      fexp = 8'(k_h[NS]) - 8'sd1;
    end
    e_next = special_h[NS] ? spbits_h[NS] : silu_pkg::round_pack(1'b0, fexp, fsig, 1'b0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tag <= '0;
    end else if (adv) begin
      out_tag <= tag_h[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_bits <= e_next;
    end
  end

endmodule

>>> rtl/core/silu_inc.sv
// two-stage half-precision add of one: exact fixed-point sum, then normalize and round
module silu_inc (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  silu_pkg::tag_t  in_tag,
  input  logic [15:0]     e_bits,
  output silu_pkg::tag_t  out_tag,
  output logic [15:0]     a_bits
);

  logic [4:0]  ef;
  logic [9:0]  man;
  logic [39:0] efix;
  logic [40:0] sum_next;
  logic [5:0]  pos_base;
  logic [5:0]  pos_next;
  logic        special_next;
  logic [15:0] spbits_next;

  always_comb begin
    ef   = e_bits[14:10];
    man  = e_bits[9:0];
    efix = 40'({ef != 5'd0, man}) << ((ef == 5'd0) ? 5'd0 : ef - 5'd1);
    sum_next = 41'(efix) + (41'd1 << 24);
    pos_base = (ef >= 5'd15) ? 6'(ef) + 6'd9 : 6'd24;
    pos_next = sum_next[pos_base + 6'd1] ? pos_base + 6'd1 : pos_base;
    special_next = (ef == 5'h1F);
    spbits_next  = (man != 10'd0) ? silu_pkg::HALF_QNAN : silu_pkg::HALF_PINF;
  end

  silu_pkg::tag_t tag_a;
  logic [40:0]    sum_a;
  logic [5:0]     pos_a;
  logic           special_a;
  logic [15:0]    spbits_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_a <= '0;
    end else if (adv) begin
      tag_a <= in_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_a     <= sum_next;
      pos_a     <= pos_next;
      special_a <= special_next;
      spbits_a  <= spbits_next;
    end
  end

  logic [40:0]       shifted;
  logic signed [7:0] aexp;
  logic [15:0]       a_next;

  always_comb begin
    shifted = sum_a << (6'd40 - pos_a);
    aexp    = $signed({2'b00, pos_a}) - 8'sd24;
    a_next  = special_a ? spbits_a
            : silu_pkg::round_pack(1'b0, aexp, shifted[40:5], |shifted[4:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tag <= '0;
    end else if (adv) begin
      out_tag <= tag_a;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_bits <= a_next;
    end
  end

endmodule

>>> rtl/core/silu_div.sv
// pipelined half-precision divide x / a, one restoring quotient bit per stage
module silu_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  silu_pkg::tag_t  in_tag,
  input  logic [15:0]     a_bits,
  output silu_pkg::tag_t  out_tag,
  output logic [15:0]     y_bits
);

  localparam int NS = silu_pkg::DIV_STEPS;

  logic [4:0]        xef;
  logic [9:0]        xman;
  logic [4:0]        aef;
  logic [9:0]        aman;
  logic              xsgn;
  logic [3:0]        msb;
  logic [10:0]       sigx;
  logic signed [7:0] ex;
  logic signed [7:0] ea;
  logic              special_next;
  logic [15:0]       spbits_next;

  always_comb begin
    xsgn = in_tag.x_bits[15];
    xef  = in_tag.x_bits[14:10];
    xman = in_tag.x_bits[9:0];
    aef  = a_bits[14:10];
    aman = a_bits[9:0];
    msb  = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (xman[i]) begin
        msb = 4'(i);
      end
    end
    if (xef != 5'd0) begin
      sigx = {1'b1, xman};
      ex   = $signed({3'b000, xef}) - 8'sd15;
    end else begin
      sigx = 11'(xman) << (4'd10 - msb);
      ex   = $signed({4'b0000, msb}) - 8'sd24;
    end
    ea = $signed({3'b000, aef}) - 8'sd15;
    special_next = 1'b1;
    spbits_next  = {xsgn, 15'd0};
    if ((xef == 5'h1F && xman != 10'd0) || (aef == 5'h1F && aman != 10'd0)
        || (xef == 5'h1F && aef == 5'h1F)) begin
      spbits_next = silu_pkg::HALF_QNAN;
    end else if (xef == 5'h1F) begin
      spbits_next = {xsgn, silu_pkg::INF_MAG};
    end else if (aef == 5'h1F || (xef == 5'd0 && xman == 10'd0)) begin
      spbits_next = {xsgn, 15'd0};
    end else begin
      special_next = 1'b0;
    end
  end

  silu_pkg::tag_t    tag_d     [0:NS];
  logic              special_d [0:NS];
  logic [15:0]       spbits_d  [0:NS];
  logic              sgn_d     [0:NS];
  logic signed [7:0] eq_d      [0:NS];
  logic [10:0]       dvs_d     [0:NS];
  logic [11:0]       rem_d     [0:NS];
  logic [12:0]       q_d       [0:NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_d[0] <= '0;
    end else if (adv) begin
      tag_d[0] <= in_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      special_d[0] <= special_next;
      spbits_d[0]  <= spbits_next;
      sgn_d[0]     <= xsgn;
      eq_d[0]      <= ex - ea;
      dvs_d[0]     <= {1'b1, aman};
      rem_d[0]     <= {1'b0, sigx};
      q_d[0]       <= 13'd0;
    end
  end

  for (genvar j = 1; j <= NS; j++) begin : g_step
    logic        ge;
    logic [11:0] diff;
    assign ge   = rem_d[j-1] >= {1'b0, dvs_d[j-1]};
    assign diff = ge ? rem_d[j-1] - {1'b0, dvs_d[j-1]} : rem_d[j-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_d[j] <= '0;
      end else if (adv) begin
        tag_d[j] <= tag_d[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        special_d[j] <= special_d[j-1];
        spbits_d[j]  <= spbits_d[j-1];
        sgn_d[j]     <= sgn_d[j-1];
        eq_d[j]      <= eq_d[j-1];
        dvs_d[j]     <= dvs_d[j-1];
        rem_d[j]     <= {diff[10:0], 1'b0};
        q_d[j]       <= {q_d[j-1][11:0], ge};
      end
    end
  end

  logic [35:0]       qsig;
  logic signed [7:0] qexp;
  logic [15:0]       y_next;

  always_comb begin
    if (q_d[NS][12]) begin
      qsig = {q_d[NS], 23'd0};
      qexp = eq_d[NS];
    end else begin
      qsig = {q_d[NS][11:0], 24'd0};
      qexp = eq_d[NS] - 8'sd1;
    end
    y_next = special_d[NS] ? spbits_d[NS]
           : silu_pkg::round_pack(sgn_d[NS], qexp, qsig, rem_d[NS] != 12'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tag <= '0;
    end else if (adv) begin
      out_tag <= tag_d[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      y_bits <= y_next;
    end
  end

endmodule

>>> rtl/core/silu_activation_fp16.sv
// top level of the fp16 silu (swish) activation: y = x / (1 + exp(-x))
//
// streams one binary16 element per transaction and returns one binary16 result per
// transaction, in order, with tlast copied from input to output. the result follows
// the step-by-step computation exp(-x), then 1 + e, then x / a, each step rounded to
// nearest even in half precision; any nan result comes out as 0x7e00, large negative
// inputs give -0 and -inf gives nan. throughput is one transaction per clock unless
// m_axis stalls, and elements are independent. the exp unit has decode, range
// reduction in two stages, nine horner stages and rounding; the add-one unit sums,
// then rounds; the divider has decode, thirteen restoring quotient stages, rounding.
// the whole pipeline advances as one: it moves whenever the output register is empty
// or its transaction is being taken, so a stall on m_axis holds every stage in place
module silu_activation_fp16 (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] x_bits
  input  logic        s_axis_tlast,   // in_last
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] y_bits
  output logic        m_axis_tlast    // out_last
);

  // global pipeline enable
  logic adv;

  silu_pkg::tag_t in_tag;
  silu_pkg::tag_t exp_tag;
  silu_pkg::tag_t inc_tag;
  silu_pkg::tag_t div_tag;
  logic [15:0]    e_bits;
  logic [15:0]    a_bits;
  logic [15:0]    y_bits;

  assign adv           = !div_tag.valid || m_axis_tready;
  assign s_axis_tready = adv;

  // the valid bit rides along with x and the last flag
  assign in_tag.valid  = s_axis_tvalid;
  assign in_tag.last   = s_axis_tlast;
  assign in_tag.x_bits = s_axis_tdata;

  // exp(-x) rounded to half
  silu_exp u_exp (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_tag  (in_tag),
    .out_tag (exp_tag),
    .e_bits  (e_bits)
  );

  // a = 1 + e rounded to half
  silu_inc u_inc (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_tag  (exp_tag),
    .e_bits  (e_bits),
    .out_tag (inc_tag),
    .a_bits  (a_bits)
  );

  // y = x / a rounded to half, last stage is the output register
  silu_div u_div (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_tag  (inc_tag),
    .a_bits  (a_bits),
    .out_tag (div_tag),
    .y_bits  (y_bits)
  );

  assign m_axis_tvalid = div_tag.valid;
  assign m_axis_tlast  = div_tag.last;
  assign m_axis_tdata  = y_bits;

endmodule

>>> rtl/core/silu_activation_fp16_checker.sv
// port-level checker for the silu activation block and its bind
`include "silu_activation_fp16_macros.svh"

module silu_activation_fp16_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  logic out_stall;
  logic out_nan;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_nan   = m_axis_tvalid && (m_axis_tdata[14:10] == 5'h1F)
                     && (m_axis_tdata[9:0] != 10'd0);

  // a stalled output transaction stays offered
  `SILU_ASSERT(a_out_hold, clk, rst, out_stall |=> m_axis_tvalid)

  // input is taken exactly when the output slot is free or draining
  `SILU_ASSERT(a_ready_rule, clk, rst, s_axis_tready == (!m_axis_tvalid || m_axis_tready))

  // the pipeline comes out of reset empty
  `SILU_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !m_axis_tvalid)

  // every nan leaves as the canonical quiet nan
  `SILU_ASSERT(a_nan_canon, clk, rst, out_nan |-> (m_axis_tdata == silu_pkg::HALF_QNAN))

endmodule

bind silu_activation_fp16 silu_activation_fp16_checker u_checker (.*);
